>>> rtl/ztt_pkg.sv
// Package for the Zobrist transposition table: action codes, entry kinds,
// controller state and command/status types. No dependencies.
`default_nettype none
package ztt_pkg;
  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_TOGGLE = 3'd1,
    ACT_LOOKUP = 3'd2,
    ACT_STORE  = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_EXACT = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_UPPER = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_WIPE,
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic wipe;
    logic capture;
    logic exec;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wipe_done;
  } ctrl_sts_t;
endpackage
`default_nettype wire

>>> rtl/ztt_ctrl.sv
// Controller state machine for the transposition table.
// Depends on ztt_pkg.
`default_nettype none
module ztt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire ztt_pkg::ctrl_sts_t sts_i,
  output ztt_pkg::ctrl_cmd_t      cmd_o
);
  import ztt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_WIPE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WIPE: if (sts_i.wipe_done) state_d = ST_IDLE;
      ST_IDLE: if (in_valid) state_d = ST_READ;
      ST_READ: state_d = ST_RESP;
      ST_RESP: if (out_ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state_q == ST_IDLE);
    out_valid   = (state_q == ST_RESP);
    cmd_o.wipe    = (state_q == ST_WIPE);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid;
    cmd_o.exec    = (state_q == ST_READ);
    cmd_o.respond = (state_q == ST_RESP);
  end

`ifndef SYNTHESIS
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready && out_valid))
    else $error("ready and valid together");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.capture |=> cmd_o.exec)
    else $error("capture not followed by exec");
  a_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_o.exec |=> out_valid)
    else $error("exec not followed by response");
`endif
endmodule
`default_nettype wire

>>> rtl/ztt_dp.sv
// Datapath: key memories, running keys, entry memories, hit logic.
// Depends on ztt_pkg.
`default_nettype none
module ztt_dp #(
  parameter int BOARD_SIZE = 15,
  parameter int INDEX_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ztt_pkg::ctrl_cmd_t cmd_i,
  output ztt_pkg::ctrl_sts_t      sts_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [4:0]         row_i,
  input  wire logic [4:0]         col_i,
  input  wire logic               stone_i,
  input  wire logic [31:0]        key_short_i,
  input  wire logic [63:0]        key_long_i,
  input  wire logic signed [15:0] window_low_i,
  input  wire logic signed [15:0] window_high_i,
  input  wire logic [5:0]         search_depth_i,
  input  wire logic               table_sel_i,
  input  wire logic [1:0]         bound_kind_i,
  input  wire logic signed [15:0] score_i,
  output logic                    hit_o,
  output logic signed [15:0]      found_score_o
);
  import ztt_pkg::*;

  localparam int Squares = BOARD_SIZE * BOARD_SIZE;
  localparam int Slots   = 2 * Squares;
  localparam int KW      = $clog2(Slots);
  localparam int EW      = INDEX_BITS + 1;
  localparam int Entries = 1 << EW;

  logic [31:0] skey_mem [Slots];
  logic [63:0] lkey_mem [Slots];
  logic [63:0] chk_mem  [Entries];
  logic [24:0] info_mem [Entries];

  logic [2:0]         act_q;
  logic               on_board_q;
  logic [KW-1:0]      kidx_q;
  logic [31:0]        ks_q;
  logic [63:0]        kl_q;
  logic signed [15:0] lo_q, hi_q, sc_q;
  logic [5:0]         dep_q;
  logic [1:0]         kind_q;
  logic [EW-1:0]      slot_q;
  logic [31:0]        rs_q;
  logic [63:0]        rl_q;
  logic [31:0]        skr_q;
  logic [63:0]        lkr_q;
  logic [63:0]        chk_r_q;
  logic [24:0]        info_r_q;
  logic [EW:0]        wipe_q;
  logic               hit_q;
  logic signed [15:0] fs_q;

  logic          on_board;
  logic [KW-1:0] kidx;
  logic [EW-1:0] slot;

  assign on_board = ({27'd0, row_i} < BOARD_SIZE) && ({27'd0, col_i} < BOARD_SIZE);
  assign kidx = KW'(({31'd0, stone_i} * Squares) + ({27'd0, row_i} * BOARD_SIZE)
                + {27'd0, col_i});
  assign slot = {table_sel_i, rs_q[INDEX_BITS-1:0]};
  assign sts_o.wipe_done = wipe_q[EW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i; on_board_q <= on_board; kidx_q <= kidx;
      ks_q <= key_short_i; kl_q <= key_long_i; lo_q <= window_low_i;
      hi_q <= window_high_i; sc_q <= score_i; dep_q <= search_depth_i;
      kind_q <= bound_kind_i; slot_q <= slot;
      skr_q <= skey_mem[kidx]; lkr_q <= lkey_mem[kidx];
      chk_r_q <= chk_mem[slot]; info_r_q <= info_mem[slot];
    end
    if (cmd_i.exec && on_board_q && act_q == ACT_LOAD) begin
      skey_mem[kidx_q] <= ks_q; lkey_mem[kidx_q] <= kl_q;
    end
    if (cmd_i.wipe) begin
      info_mem[wipe_q[EW-1:0]] <= '0;
      chk_mem[wipe_q[EW-1:0]] <= '0;
    end else if (cmd_i.exec && act_q == ACT_STORE && kind_q != KIND_NONE) begin
      chk_mem[slot_q] <= rl_q;
      info_mem[slot_q] <= {1'b1, kind_q, dep_q, sc_q};
    end
  end

  logic               e_hit;
  logic signed [15:0] e_sc;
  always_comb begin
    e_sc  = $signed(info_r_q[15:0]);
    e_hit = 1'b0;
    if (act_q == ACT_LOOKUP && info_r_q[24] && info_r_q[21:16] >= dep_q && chk_r_q == rl_q) begin
      case (kind_e'(info_r_q[23:22]))
        KIND_EXACT: e_hit = 1'b1;
        KIND_LOWER: e_hit = e_sc >= hi_q;
        KIND_UPPER: e_hit = e_sc <= lo_q;
        default:    e_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= '0; rl_q <= '0; wipe_q <= '0; hit_q <= 1'b0; fs_q <= '0;
    end else begin
      if (cmd_i.wipe) wipe_q <= wipe_q + 1'b1;
      if (cmd_i.exec) begin
        hit_q <= e_hit;
        fs_q  <= e_hit ? e_sc : 16'sd0;
        if (act_q == ACT_TOGGLE && on_board_q) begin
          rs_q <= rs_q ^ skr_q; rl_q <= rl_q ^ lkr_q;
        end else if (act_q == ACT_CLEAR) begin
          rs_q <= '0; rl_q <= '0;
        end
      end
    end
  end

  assign hit_o = hit_q;
  assign found_score_o = fs_q;

`ifndef SYNTHESIS
  a_fs: assert property (@(posedge clk_i) disable iff (!rst_ni) !hit_q |-> fs_q == 16'sd0)
    else $error("score without hit");
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && act_q == ACT_CLEAR |=> rs_q == '0 && rl_q == '0)
    else $error("clear failed");
  a_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wipe |-> !cmd_i.exec) else $error("exec during wipe");
`endif
endmodule
`default_nettype wire

>>> rtl/zobrist_transposition_table_top.sv
// The result is registered in the read step after capture and held in the response state.
// Items are handled one at a time through the capture, read and response steps of the
// controller, and a stalled result holds off the next transaction.
// After reset a clearing pass wipes the 2*2^INDEX_BITS entries, one per cycle, and the
// first transaction is accepted only after the pass ends. Depends on ztt_pkg,
// ztt_ctrl, ztt_dp.
`default_nettype none
module zobrist_transposition_table_top #(
  parameter int BOARD_SIZE = 15,
  parameter int INDEX_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         action_i,
  input  wire logic [4:0]         row_i,
  input  wire logic [4:0]         col_i,
  input  wire logic               stone_i,
  input  wire logic [31:0]        key_short_i,
  input  wire logic [63:0]        key_long_i,
  input  wire logic signed [15:0] window_low_i,
  input  wire logic signed [15:0] window_high_i,
  input  wire logic [5:0]         search_depth_i,
  input  wire logic               table_sel_i,
  input  wire logic [1:0]         bound_kind_i,
  input  wire logic signed [15:0] score_i,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit_o,
  output logic signed [15:0]      found_score_o
);
  import ztt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ztt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts_i(sts), .cmd_o(cmd)
  );

  ztt_dp #(.BOARD_SIZE(BOARD_SIZE), .INDEX_BITS(INDEX_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i, .row_i, .col_i, .stone_i, .key_short_i, .key_long_i,
    .window_low_i, .window_high_i, .search_depth_i, .table_sel_i,
    .bound_kind_i, .score_i, .hit_o, .found_score_o
  );
endmodule
`default_nettype wire
